// File: rtl/rotary_position_debouncer_defines.svh
// assertion macros for the rotary position debouncer
`ifndef ROTARY_POSITION_DEBOUNCER_DEFINES_SVH
`define ROTARY_POSITION_DEBOUNCER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rpd assertion failed");

// next-cycle implication, checked outside reset
`define RPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rpd assertion failed");

`endif

// File: rtl/rpd_pkg.sv
// shared types, constants and functions of the rotary position debouncer
package rpd_pkg;

  localparam int unsigned LevelsW    = 3;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned PosW       = 2;
  localparam int unsigned OnehotW    = 4;
  localparam int unsigned MsCfgW     = 16;
  localparam int unsigned ThrW       = 8;
  localparam int unsigned CountW     = 8;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [MsCfgW-1:0] DebounceMsRst     = 16'd50;
  localparam logic [MsCfgW-1:0] IdleHoldMsRst     = 16'd1000;
  localparam logic [ThrW-1:0]   StableThresholdRst = 8'd3;
  localparam logic [CountW-1:0] CountMax          = 8'd255;

  localparam logic [PosW-1:0] PosIdle = 2'd0;
  localparam logic [PosW-1:0] PosOne  = 2'd1;
  localparam logic [PosW-1:0] PosTwo  = 2'd2;
  localparam logic [PosW-1:0] PosThree = 2'd3;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_SETTLE_MS    = 2'd0,
    CFG_IDLE_HOLD_MS = 2'd1,
    CFG_MIN_REPEATS  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [MsCfgW-1:0] settle_ms;
    logic [MsCfgW-1:0] idle_hold_ms;
    logic [ThrW-1:0]   min_repeats;
  } cfg_t;

  typedef struct packed {
    logic [LevelsW-1:0] raw_levels;
    logic [TimeW-1:0]   now_ms;
  } item_t;

  typedef struct packed {
    logic [OnehotW-1:0] position_onehot;
    logic [PosW-1:0]    accepted_position;
    logic               position_known;
  } result_t;

  function automatic logic [PosW-1:0] pattern_to_position(input logic [LevelsW-1:0] pattern);
    logic [PosW-1:0] pos;
    case (pattern)
      3'b001:  pos = PosThree;
      3'b010:  pos = PosTwo;
      3'b100:  pos = PosOne;
      default: pos = PosIdle;
    endcase
    return pos;
  endfunction

endpackage

// File: rtl/rotary_position_debouncer.sv
// top level of the rotary position debouncer
// path: an accepted poll transaction is registered in the input stage, and its result in the result register
// throughput: one poll per cycle while the output side is ready
// the state update between the input and result registers sets the rate
// reset: asynchronous, active low; clears state, history and valid flags,
// and loads the register defaults (50 ms, 1000 ms, threshold 3)
module rotary_position_debouncer
  import rpd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [LevelsW-1:0]   raw_levels_i,
  input  logic [TimeW-1:0]     now_ms_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OnehotW-1:0]   position_onehot_o,
  output logic [PosW-1:0]      accepted_position_o,
  output logic                 position_known_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    out_can_load;
  logic    step;
  result_t filt_result;
  result_t out_result;

  assign in_item.raw_levels = raw_levels_i;
  assign in_item.now_ms     = now_ms_i;
  assign step               = stage_valid && out_can_load;

  rpd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rpd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (step),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  rpd_filter u_filter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .item_i   (stage_item),
    .result_o (filt_result)
  );

  rpd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (filt_result),
    .can_load_o  (out_can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign position_onehot_o   = out_result.position_onehot;
  assign accepted_position_o = out_result.accepted_position;
  assign position_known_o    = out_result.position_known;

endmodule

// File: rtl/rpd_cfg_regs.sv
// configuration register bank
module rpd_cfg_regs
  import rpd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SETTLE_MS:    cfg_d.settle_ms = cfg_data_i[MsCfgW-1:0];
        CFG_IDLE_HOLD_MS: cfg_d.idle_hold_ms = cfg_data_i[MsCfgW-1:0];
        CFG_MIN_REPEATS:  cfg_d.min_repeats = cfg_data_i[ThrW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ms    <= DebounceMsRst;
      cfg_q.idle_hold_ms <= IdleHoldMsRst;
      cfg_q.min_repeats  <= StableThresholdRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/rpd_in_stage.sv
// input register stage for poll transactions
module rpd_in_stage
  import rpd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  logic  take_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d = 1'b1;
      item_d  = item_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/rpd_filter.sv
// stability counter, hold-time check and accepted position state
module rpd_filter
  import rpd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    step_i,
  input  item_t   item_i,
  output result_t result_o
);

  `include "rotary_position_debouncer_defines.svh"

  logic [LevelsW-1:0] prev_pattern_q, prev_pattern_d;
  logic               seen_q, seen_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [PosW-1:0]    held_q, held_d;
  logic               held_valid_q, held_valid_d;
  logic [TimeW-1:0]   last_ms_q, last_ms_d;

  logic [LevelsW-1:0] pattern;
  logic [PosW-1:0]    pos;
  logic               same;
  logic [CountW-1:0]  count_next;
  logic               change;
  logic [TimeW-1:0]   need;
  logic [TimeW-1:0]   elapsed;
  logic               accept;

  always_comb begin
    pattern    = ~item_i.raw_levels;
    pos        = pattern_to_position(pattern);
    same       = seen_q && (pattern == prev_pattern_q);
    if (!same) begin
      count_next = '0;
    end else if (count_q == CountMax) begin
      count_next = count_q;
    end else begin
      count_next = count_q + 1'b1;
    end
    change     = !held_valid_q || (pos != held_q);
    need       = (pos == PosIdle) ? {{(TimeW-MsCfgW){1'b0}}, cfg_i.idle_hold_ms}
                                  : {{(TimeW-MsCfgW){1'b0}}, cfg_i.settle_ms};
    elapsed    = item_i.now_ms - last_ms_q;
    accept     = change && (count_next >= cfg_i.min_repeats) && (elapsed >= need);
  end

  always_comb begin
    prev_pattern_d = prev_pattern_q;
    seen_d         = seen_q;
    count_d        = count_q;
    held_d         = held_q;
    held_valid_d   = held_valid_q;
    last_ms_d      = last_ms_q;
    if (step_i) begin
      count_d = count_next;
      if (!same) begin
        prev_pattern_d = pattern;
        seen_d         = 1'b1;
      end
      if (accept) begin
        held_d       = pos;
        held_valid_d = 1'b1;
        last_ms_d    = item_i.now_ms;
      end
    end
  end

  always_comb begin
    result_o.position_known    = held_valid_d;
    result_o.accepted_position = held_valid_d ? held_d : PosIdle;
    result_o.position_onehot   = held_valid_d ? (OnehotW'(1) << held_d) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pattern_q <= '0;
      seen_q         <= 1'b0;
      count_q        <= '0;
      held_q         <= PosIdle;
      held_valid_q   <= 1'b0;
      last_ms_q      <= '0;
    end else begin
      prev_pattern_q <= prev_pattern_d;
      seen_q         <= seen_d;
      count_q        <= count_d;
      held_q         <= held_d;
      held_valid_q   <= held_valid_d;
      last_ms_q      <= last_ms_d;
    end
  end

  // once known, the position never becomes unknown
  `RPD_ASSERT_NEXT(a_known_sticky, held_valid_q, held_valid_q)
  // an accepted change stamps the transaction time
  `RPD_ASSERT_NEXT(a_stamp_on_accept, step_i && accept,
                   held_valid_q && (last_ms_q == $past(item_i.now_ms)))
  // a new pattern restarts the stability count
  `RPD_ASSERT_NEXT(a_count_restart, step_i && !same, count_q == '0)
  // no change is accepted below the stability threshold
  `RPD_ASSERT_NOW(a_thr_gate, step_i && accept, count_next >= cfg_i.min_repeats)

endmodule

// File: rtl/rpd_out_stage.sv
// result register stage
module rpd_out_stage
  import rpd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    can_load_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q, result_d;

  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d  = valid_q;
    result_d = result_q;
    if (load_i) begin
      valid_d  = 1'b1;
      result_d = result_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule
